// ===== design/target_speed_estimator_assert.svh =====
// assertion macros used by the speed estimator module
`ifndef TARGET_SPEED_ESTIMATOR_ASSERT_SVH
`define TARGET_SPEED_ESTIMATOR_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define TSE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tse assertion failed");
// next-cycle implication, checked out of reset
`define TSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tse assertion failed");
`else
`define TSE_ASSERT_IMPL(lbl, ante, cons)
`define TSE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/tse_pkg.sv =====
// package with shared constants and types of the target speed estimator
package tse_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int TIME_W       = 32;
    localparam int POS_W        = 32;
    localparam int SPEED_W      = 32;
    localparam int THR_W        = 31;
    localparam int IDLE_W       = 16;
    localparam int DP_W         = POS_W + 1;
    localparam int MS_W         = 10;
    localparam int MAG_W        = DP_W + 9;
    localparam int CNT_W        = $clog2(MAG_W + 1);
    localparam int CFG_W        = 32;

    localparam logic [MS_W-1:0]   MS_PER_SECOND = MS_W'(1000);
    localparam logic [THR_W-1:0]  SLEW_RESET    = THR_W'(10) << FRAC_BITS;
    localparam logic [IDLE_W-1:0] STALE_RESET   = IDLE_W'(200);
    localparam logic [IDLE_W-1:0] IDLE_MAX      = {IDLE_W{1'b1}};

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_SLEW_THRESHOLD = 1'b0,
        REG_STALE_TIMEOUT  = 1'b1
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_SAT  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

endpackage

// ===== design/target_speed_estimator.sv =====
// Target speed estimator: finite-difference speed with slew limit and stale timeout.
// Input channel s_*: one transfer per position sample (time in ms, Q16.16 position).
// Result channel m_*: exactly one transfer per input item, carrying the filtered
// and raw speed in tdata and the updated / stale flags in tuser.
// Config channel cfg_*: index 0 writes slew_threshold, index 1 writes stale_timeout;
// always ready, write only while no item is in flight.
// An item with a new timestamp goes from accept to result through prep, scale,
// 42 restoring divider steps plus its done strobe, saturate and load.
// An item with a repeated timestamp goes through prep and load only. s_tready is
// high only while idle, so a new item is accepted only after the last one is
// loaded, and the final state may also wait on the receiver.
// The result sits in an output register: the next item is accepted while it waits,
// and a stalled receiver only holds the sequencer in its final state.
// Reset (aresetn low, synchronous) clears the stored time, position, speeds and
// idle count, loads the default threshold (10.0 in Q16.16) and timeout (200),
// and drops m_tvalid.
module target_speed_estimator
    import tse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] sample_time, [63:32] position
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] filtered_speed, [63:32] raw_speed
    output logic [1:0]  m_tuser    // [0] updated, [1] stale
);

`include "target_speed_estimator_assert.svh"

    state_t state_reg, state_next;

    logic [THR_W-1:0]         slew_reg;
    logic [IDLE_W-1:0]        timeout_reg;

    logic [TIME_W-1:0]        last_time_reg;
    logic signed [POS_W-1:0]  last_pos_reg;
    logic signed [SPEED_W-1:0] last_raw_reg;
    logic signed [SPEED_W-1:0] held_reg;
    logic [IDLE_W-1:0]        idle_reg;

    logic [TIME_W-1:0]        in_time_reg;
    logic signed [POS_W-1:0]  in_pos_reg;
    logic                     upd_reg;
    logic [TIME_W-1:0]        dt_reg;
    logic                     neg_reg;
    logic [DP_W-1:0]          absdp_reg;
    logic signed [SPEED_W-1:0] raw_reg;

    logic                     m_tvalid_reg;
    logic [63:0]              m_tdata_reg;
    logic [1:0]               m_tuser_reg;

    logic                     s_fire, cfg_fire, out_free, fin_fire;
    logic signed [DP_W-1:0]   dp;
    logic [MAG_W:0]           product;
    logic                     div_start, div_done;
    logic [MAG_W-1:0]         quot;
    logic [SPEED_W-1:0]       raw_sat;
    logic signed [SPEED_W+1:0] diff, thr_s, held_cand;
    logic [IDLE_W-1:0]        idle_new;
    logic                     stale_new;
    logic signed [SPEED_W-1:0] held_new;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign fin_fire  = (state_reg == ST_FIN) && out_free;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_PREP;
            ST_PREP: state_next = (in_time_reg != last_time_reg) ? ST_MUL : ST_FIN;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_SAT;
            ST_SAT:  state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // position difference and scaling by 1000
    assign dp        = DP_W'(in_pos_reg) - DP_W'(last_pos_reg);
    assign product   = (MAG_W + 1)'(absdp_reg) * (MAG_W + 1)'(MS_PER_SECOND);
    assign div_start = (state_reg == ST_MUL);

    tse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product[MAG_W-1:0]),
        .divisor  (dt_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // signed saturation of the quotient
    always_comb begin
        if (neg_reg) begin
            if (quot > MAG_W'(33'h080000000))
                raw_sat = 32'h80000000;
            else
                raw_sat = SPEED_W'(-quot[SPEED_W-1:0]);
        end else begin
            if (quot > MAG_W'(32'h7FFFFFFF))
                raw_sat = 32'h7FFFFFFF;
            else
                raw_sat = quot[SPEED_W-1:0];
        end
    end

    // slew limit, idle count and stale check
    always_comb begin
        thr_s = (SPEED_W + 2)'({1'b0, slew_reg});
        diff  = (SPEED_W + 2)'(raw_reg) - (SPEED_W + 2)'(held_reg);
        if (diff < -thr_s)
            held_cand = (SPEED_W + 2)'(held_reg) - thr_s;
        else if (diff > thr_s)
            held_cand = (SPEED_W + 2)'(held_reg) + thr_s;
        else
            held_cand = (SPEED_W + 2)'(raw_reg);
        if (!upd_reg)
            held_cand = (SPEED_W + 2)'(held_reg);
        if (upd_reg)
            idle_new = '0;
        else if (idle_reg != IDLE_MAX)
            idle_new = idle_reg + IDLE_W'(1);
        else
            idle_new = idle_reg;
        stale_new = idle_new > timeout_reg;
        held_new  = stale_new ? '0 : held_cand[SPEED_W-1:0];
    end

    // control, configuration and estimator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            slew_reg      <= SLEW_RESET;
            timeout_reg   <= STALE_RESET;
            last_time_reg <= '0;
            last_pos_reg  <= '0;
            last_raw_reg  <= '0;
            held_reg      <= '0;
            idle_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_fire) begin
                case (cfg_reg_t'(cfg_index))
                    REG_SLEW_THRESHOLD: slew_reg    <= cfg_data[THR_W-1:0];
                    REG_STALE_TIMEOUT:  timeout_reg <= cfg_data[IDLE_W-1:0];
                    default: ;
                endcase
            end
            if (fin_fire) begin
                held_reg <= held_new;
                idle_reg <= idle_new;
                if (upd_reg) begin
                    last_raw_reg  <= raw_reg;
                    last_time_reg <= in_time_reg;
                    last_pos_reg  <= in_pos_reg;
                end
            end
            if (fin_fire)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_time_reg <= s_tdata[TIME_W-1:0];
            in_pos_reg  <= s_tdata[TIME_W+POS_W-1:TIME_W];
        end
        if (state_reg == ST_PREP) begin
            upd_reg   <= (in_time_reg != last_time_reg);
            dt_reg    <= in_time_reg - last_time_reg;
            neg_reg   <= dp[DP_W-1];
            absdp_reg <= dp[DP_W-1] ? DP_W'(-dp) : DP_W'(dp);
        end
        if (state_reg == ST_SAT)
            raw_reg <= raw_sat;
        if (fin_fire) begin
            m_tdata_reg <= {(upd_reg ? raw_reg : last_raw_reg), held_new};
            m_tuser_reg <= {stale_new, upd_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a stale result always reports zero filtered speed
    `TSE_ASSERT_IMPL(a_stale_zero, m_tvalid && m_tuser[1], m_tdata[31:0] == '0)
    // an update clears the idle count, so it is never stale
    `TSE_ASSERT_IMPL(a_upd_not_stale, m_tvalid, !(m_tuser[0] && m_tuser[1]))
    // the divider finishes only while the sequencer waits on it
    `TSE_ASSERT_IMPL(a_div_done_state, div_done, state_reg == ST_DIV)
    // a result is loaded only once the previous one was taken
    `TSE_ASSERT_NEXT(a_fin_free, (state_reg == ST_FIN) && m_tvalid && !m_tready,
                     state_reg == ST_FIN)

endmodule

// ===== design/tse_div.sv =====
// restoring divider, one quotient bit per cycle
module tse_div
    import tse_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MAG_W-1:0]  dividend,
    input  logic [TIME_W-1:0] divisor,
    output logic              done,
    output logic [MAG_W-1:0]  quotient
);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [MAG_W-1:0]  dq_reg,    dq_next;
    logic [TIME_W-1:0] rem_reg,   rem_next;
    logic [TIME_W-1:0] dvs_reg,   dvs_next;
    logic [TIME_W:0]   rem_sh;
    logic              ge;

    // load on start, else one shift-subtract step while busy
    always_comb begin
        rem_sh    = {rem_reg, dq_reg[MAG_W-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            dq_next  = {dq_reg[MAG_W-2:0], ge};
            rem_next = ge ? TIME_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[TIME_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ===== sim/target_speed_estimator_checker.sv =====
// scoreboard for the target speed estimator: predicts each result and compares transfers
module target_speed_estimator_checker
    import tse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          result_count
);

    typedef struct packed {
        logic [31:0] filtered;
        logic [31:0] raw;
        logic        updated;
        logic        stale;
    } speed_result_t;

    // predicted copy of the block state and registers
    logic [THR_W-1:0]  slew_thr;
    logic [IDLE_W-1:0] stale_limit;
    logic [31:0]       last_stamp;
    logic [31:0]       last_pos;
    logic [31:0]       last_raw;
    logic [31:0]       held_speed;
    logic [IDLE_W-1:0] idle_cnt;

    speed_result_t pending_speeds[$];

    // advance the predicted state by one sample and return the expected result
    function automatic speed_result_t estimate_speed(logic [31:0] stamp, logic [31:0] pos);
        speed_result_t      res;
        logic [31:0]        dt;
        logic [31:0]        raw;
        longint             dp;
        longint             diff;
        longint             thr;
        longint unsigned    mag;
        longint unsigned    quo;
        res = '0;
        if (stamp != last_stamp) begin
            dt  = stamp - last_stamp;
            dp  = longint'($signed(pos)) - longint'($signed(last_pos));
            mag = (dp < 0) ? -dp : dp;
            mag = mag * MS_PER_SECOND;
            quo = mag / {32'd0, dt};
            // truncate toward zero, then clamp to the 32-bit signed range
            if (dp < 0) begin
                if (quo > 64'h8000_0000)
                    quo = 64'h8000_0000;
                raw = -quo[31:0];
            end else begin
                if (quo > 64'h7FFF_FFFF)
                    quo = 64'h7FFF_FFFF;
                raw = quo[31:0];
            end
            // slew limit on the held speed
            diff = longint'($signed(raw)) - longint'($signed(held_speed));
            thr  = longint'(slew_thr);
            if (diff < -thr)
                held_speed = 32'(longint'($signed(held_speed)) - thr);
            else if (diff > thr)
                held_speed = 32'(longint'($signed(held_speed)) + thr);
            else
                held_speed = raw;
            last_raw    = raw;
            last_stamp  = stamp;
            last_pos    = pos;
            idle_cnt    = '0;
            res.updated = 1'b1;
        end else if (idle_cnt != IDLE_MAX) begin
            idle_cnt = idle_cnt + 1'b1;
        end
        // stale timeout zeroes the speed
        if (idle_cnt > stale_limit) begin
            held_speed = '0;
            res.stale  = 1'b1;
        end
        res.filtered = held_speed;
        res.raw      = last_raw;
        return res;
    endfunction

    // watch the channels at each edge
    always @(posedge aclk) begin
        speed_result_t want;
        speed_result_t got;
        if (!aresetn) begin
            slew_thr     = SLEW_RESET;
            stale_limit  = STALE_RESET;
            last_stamp   = '0;
            last_pos     = '0;
            last_raw     = '0;
            held_speed   = '0;
            idle_cnt     = '0;
            pending_speeds.delete();
            fail_count   <= 0;
            result_count <= 0;
        end else begin
            // register write transfer
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SLEW_THRESHOLD)
                    slew_thr = cfg_data[THR_W-1:0];
                else
                    stale_limit = cfg_data[IDLE_W-1:0];
            end
            // result transfer against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.filtered = m_tdata[31:0];
                got.raw      = m_tdata[63:32];
                got.updated  = m_tuser[0];
                got.stale    = m_tuser[1];
                result_count <= result_count + 1;
                if (pending_speeds.size() == 0) begin
                    fail_count <= fail_count + 1;
                    $display("%0t: unexpected result transfer, expected none, actual %h %b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = pending_speeds.pop_front();
                    if (got !== want) begin
                        fail_count <= fail_count + 1;
                        if (got.filtered !== want.filtered)
                            $display("%0t: filtered_speed expected %0d, actual %0d", $time,
                                     $signed(want.filtered), $signed(got.filtered));
                        if (got.raw !== want.raw)
                            $display("%0t: raw_speed expected %0d, actual %0d", $time,
                                     $signed(want.raw), $signed(got.raw));
                        if (got.updated !== want.updated)
                            $display("%0t: updated expected %b, actual %b", $time,
                                     want.updated, got.updated);
                        if (got.stale !== want.stale)
                            $display("%0t: stale expected %b, actual %b", $time,
                                     want.stale, got.stale);
                    end
                end
            end
            // input transfer
            if (s_tvalid && s_tready)
                pending_speeds.push_back(estimate_speed(s_tdata[31:0], s_tdata[63:32]));
        end
    end

endmodule

// ===== sim/target_speed_estimator_tb.sv =====
// testbench top for the target speed estimator: stimulus, flow control and verdict
module target_speed_estimator_tb;
    import tse_pkg::*;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    int          fail_count;
    int          result_count;
    int          samples_sent = 0;
    bit          tx_burst     = 1'b0;
    bit          rx_steady    = 1'b0;

    // trajectory of the simulated target
    logic [31:0] track_time = 32'h8000_0000;
    logic [31:0] track_pos  = 32'hFFFF_FFFF;
    logic [31:0] track_rate = 32'h0001_0000;

    target_speed_estimator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    target_speed_estimator_checker speed_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .result_count (result_count)
    );

    always #5 aclk = ~aclk;

    // idle length: mostly short, a few long
    function automatic int pick_gap(int shortest);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return shortest;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 90);
    endfunction

    // length of a stretch with the receiver ready
    function automatic int ready_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 8);
        else if (r < 95)
            return $urandom_range(9, 40);
        return $urandom_range(100, 300);
    endfunction

    // one sample transfer on the input channel
    task automatic send_sample(input logic [31:0] stamp, input logic [31:0] pos);
        int gap;
        gap = tx_burst ? 0 : pick_gap(0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, stamp};
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    // hold the sender until every result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (result_count < samples_sent);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly smooth motion, with repeated stamps, jumps, wraps and noise
    task automatic drive_track(input int count);
        int          n;
        int          kind;
        int          reps;
        int          r;
        logic [31:0] step;
        n = 0;
        while (n < count) begin
            if (n % 40 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                send_sample($urandom, $urandom);
                n++;
            end else if (kind < 20) begin
                reps = $urandom_range(1, 8);
                repeat (reps) send_sample(track_time, $urandom);
                n += reps;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    step = $urandom_range(1, 40);
                else if (r < 90)
                    step = $urandom_range(41, 5000);
                else if (r < 97)
                    step = $urandom;
                else
                    step = 32'd0 - track_time + $urandom_range(0, 20);
                if ($urandom_range(0, 15) == 0)
                    track_rate = ($urandom_range(0, 5) == 0) ? $urandom
                                                             : $urandom_range(0, 32'h0020_0000)
                                                               - 32'h0010_0000;
                track_time = track_time + step;
                track_pos  = track_pos + track_rate * step + $urandom_range(0, 255);
                if ($urandom_range(0, 30) == 0)
                    track_pos = $urandom;
                send_sample(track_time, track_pos);
                n++;
            end
        end
        tx_burst = 1'b0;
    endtask

    // receiver flow control
    initial begin
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat (rx_steady ? 64 : ready_span()) @(posedge aclk);
            if (!rx_steady) begin
                m_tready <= 1'b0;
                repeat (pick_gap(1)) @(posedge aclk);
            end
        end
    end

    // main sequence
    initial begin
        int ph;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: first sample at time zero, saturation both ways, time wrap
        send_sample(32'd0, 32'd0);
        send_sample(32'd0, 32'h7FFF_FFFF);
        send_sample(32'd1, 32'h7FFF_FFFF);
        send_sample(32'd2, 32'h8000_0000);
        send_sample(32'd3, 32'h8000_0000);
        send_sample(32'hFFFF_FFFF, 32'h8000_0100);
        send_sample(32'd4, 32'h8001_0000);
        send_sample(32'd4, 32'h0000_0000);
        drain_results();

        // zero threshold and immediate stale timeout
        write_reg(REG_SLEW_THRESHOLD, 32'd0);
        write_reg(REG_STALE_TIMEOUT, 32'd0);
        send_sample(32'd10, 32'h0064_0000);
        send_sample(32'd10, 32'h0064_0000);
        send_sample(32'd11, 32'h0065_0000);
        drain_results();

        // widest threshold, full-scale swings, then a short timeout
        write_reg(REG_SLEW_THRESHOLD, 32'hFFFF_FFFF);
        write_reg(REG_STALE_TIMEOUT, 32'hFFFF_0002);
        send_sample(32'd12, 32'h7FFF_FFFF);
        send_sample(32'd13, 32'h8000_0000);
        repeat (3) send_sample(32'd13, 32'h1234_5678);
        send_sample(32'h8000_0000, 32'hFFFF_FFFF);

        // random phases, each under its own register setting
        for (ph = 0; ph < 6; ph++) begin
            drain_results();
            case (ph)
                0: begin
                    write_reg(REG_SLEW_THRESHOLD, $urandom_range(1, 32'h0010_0000));
                    write_reg(REG_STALE_TIMEOUT, $urandom_range(0, 5));
                end
                1: begin
                    write_reg(REG_SLEW_THRESHOLD, 32'd0);
                    write_reg(REG_STALE_TIMEOUT, 32'd0);
                end
                2: begin
                    write_reg(REG_SLEW_THRESHOLD, 32'h7FFF_FFFF);
                    write_reg(REG_STALE_TIMEOUT, {16'($urandom_range(0, 16'hFFFF)),
                                                  16'hFFFE});
                end
                3: begin
                    write_reg(REG_SLEW_THRESHOLD, $urandom);
                    write_reg(REG_STALE_TIMEOUT, {16'($urandom_range(0, 16'hFFFF)),
                                                  16'($urandom_range(1, 10))});
                end
                4: begin
                    write_reg(REG_SLEW_THRESHOLD, $urandom_range(1, 200));
                    write_reg(REG_STALE_TIMEOUT, 32'd1);
                end
                default: begin
                    write_reg(REG_SLEW_THRESHOLD, $urandom);
                    write_reg(REG_STALE_TIMEOUT, 32'd200);
                end
            endcase
            drive_track(100);
        end

        // largest timeout: a run of repeated stamps never goes stale
        drain_results();
        write_reg(REG_STALE_TIMEOUT, 32'hA5A5_FFFF);
        rx_steady = 1'b1;
        tx_burst  = 1'b1;
        track_time = track_time + 32'd7;
        send_sample(track_time, track_pos);
        repeat (20) send_sample(track_time, $urandom);
        drain_results();

        // timeout below the running idle count trips on the next repeat
        write_reg(REG_STALE_TIMEOUT, 32'h0000_0010);
        repeat (3) send_sample(track_time, $urandom);
        tx_burst  = 1'b0;
        rx_steady = 1'b0;

        // wind down
        drain_results();
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== target_speed_estimator.f =====
+incdir+design
design/tse_pkg.sv
design/tse_div.sv
design/target_speed_estimator.sv
sim/target_speed_estimator_checker.sv
sim/target_speed_estimator_tb.sv
